// File: design/usbhpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// USB hub port tracker package
// Shared types, command codes, port state codes and the per-port state
// update function used by the tracker datapath.
// ----------------------------------------------------------------------------
package usbhpt_pkg;

    // Default number of ports and the reset value of the enable delay.
    localparam int          PORTS_DEFAULT = 4;
    localparam logic [15:0] DELAY_RESET   = 16'd10;

    // Command codes carried on the cmd field.
    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_CONNECT      = 3'd1,
        CMD_FIND         = 3'd2,
        CMD_SET_STATE    = 3'd3,
        CMD_SET_ALL      = 3'd4,
        CMD_CLEAR_CHANGE = 3'd5,
        CMD_READ_PORT    = 3'd6,
        CMD_READ_BITMAP  = 3'd7
    } cmd_t;

    // Port state codes.
    localparam logic [2:0] ST_UNCONF    = 3'd0;
    localparam logic [2:0] ST_OFF       = 3'd1;
    localparam logic [2:0] ST_DISCONN   = 3'd2;
    localparam logic [2:0] ST_DISABLED  = 3'd3;
    localparam logic [2:0] ST_RESETTING = 3'd4;
    localparam logic [2:0] ST_ENABLED   = 3'd5;
    localparam logic [2:0] ST_SUSPENDED = 3'd6;
    localparam logic [2:0] ST_RESUMING  = 3'd7;

    // Reported state for a port that does not exist or was not found.
    localparam logic [3:0] ST_UNKNOWN = 4'd8;

    // Change bits in the hub port change layout.
    localparam logic [15:0] CH_CONNECTION = 16'h0001;
    localparam logic [15:0] CH_ENABLE     = 16'h0002;
    localparam logic [15:0] CH_RESET      = 16'h0010;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } dp_cmd_t;

    // Updated per-port fields after a state write.
    typedef struct packed {
        logic [2:0]  state;
        logic [15:0] change;
        logic [15:0] count;
        logic [2:0]  pend;
    } port_upd_t;

    // Apply a state write to one port. start is the countdown load value.
    function automatic port_upd_t port_set_state(
        input logic [2:0]  cur,
        input logic [2:0]  st,
        input logic [15:0] change,
        input logic [15:0] count,
        input logic [2:0]  pend,
        input logic [15:0] start
    );
        port_upd_t u;
        u.state  = st;
        u.change = change;
        u.count  = count;
        u.pend   = pend;
        case (st)
            ST_OFF:
            begin
                u.change = change & ~(CH_CONNECTION | CH_ENABLE | CH_RESET);
            end
            ST_RESETTING, ST_RESUMING:
            begin
                u.count = start;
                u.pend  = st;
            end
            ST_ENABLED:
            begin
                if (cur == ST_RESETTING)
                begin
                    u.change = change | CH_RESET;
                end
            end
            default:
            begin
                u.state = st;
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: design/usb_hub_port_state_tracker_unit.sv
// out_valid rises after the input transfer passes execute, then result load.
// The controller handles one command at a time; the next is taken after the
// result register is loaded. A stalled output holds the controller in its
// result state. Reset clears all port state, change bits, countdowns and the
// valid bits, and sets the enable delay to 10 ticks.
`default_nettype none
// ----------------------------------------------------------------------------
// USB hub port state tracker
// Top level: joins the controller and the per-port datapath and provides
// the command, result and configuration channels.
// ----------------------------------------------------------------------------
module usb_hub_port_state_tracker_unit #(
    parameter int PORTS = usbhpt_pkg::PORTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  port,
    input  wire logic [2:0]  target_state,
    input  wire logic [15:0] change_mask,
    input  wire logic [15:0] device_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [2:0]       port_found,
    output logic [3:0]       port_state,
    output logic [31:0]      status_word,
    output logic [7:0]       change_bitmap,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    usbhpt_pkg::dp_cmd_t dp_cmd;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    usbhpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    usbhpt_dp #(
        .PORTS (PORTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .cmd           (cmd),
        .port          (port),
        .target_state  (target_state),
        .change_mask   (change_mask),
        .device_id     (device_id),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .ok            (ok),
        .port_found    (port_found),
        .port_state    (port_state),
        .status_word   (status_word),
        .change_bitmap (change_bitmap)
    );

    // One command at a time: no transfer is taken right after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in flight");

    // Loading the result register always presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |=> out_valid)
        else $error("result load did not raise out_valid");

    // A failed result never reports a port number.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> port_found == 3'd0)
        else $error("failed result carries a port number");

    // Bit 0 of the change bitmap is never set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !change_bitmap[0])
        else $error("change bitmap bit 0 set");

endmodule
`default_nettype wire

// File: design/usbhpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// USB hub port tracker controller
// Sequences each transfer through capture, execute and result load, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module usbhpt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output usbhpt_pkg::dp_cmd_t     dp_cmd
);

    usbhpt_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    // The result register can take a new value when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= usbhpt_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            usbhpt_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = usbhpt_pkg::CS_EXEC;
                end
            end
            usbhpt_pkg::CS_EXEC:
            begin
                state_next = usbhpt_pkg::CS_RESULT;
            end
            usbhpt_pkg::CS_RESULT:
            begin
                if (out_free)
                begin
                    state_next = usbhpt_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = usbhpt_pkg::CS_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        in_ready         = 1'b0;
        dp_cmd.capture   = 1'b0;
        dp_cmd.exec      = 1'b0;
        dp_cmd.load_out  = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        case (state_reg)
            usbhpt_pkg::CS_IDLE:
            begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
            end
            usbhpt_pkg::CS_EXEC:
            begin
                dp_cmd.exec = 1'b1;
            end
            usbhpt_pkg::CS_RESULT:
            begin
                if (out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    out_valid_next  = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: design/usbhpt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// USB hub port tracker datapath
// Holds the per-port state, change masks, attached ids and enable
// countdowns, executes one command and forms the result transfer.
// ----------------------------------------------------------------------------
module usbhpt_dp #(
    parameter int PORTS = usbhpt_pkg::PORTS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire usbhpt_pkg::dp_cmd_t dp_cmd,
    input  wire logic [2:0]          cmd,
    input  wire logic [2:0]          port,
    input  wire logic [2:0]          target_state,
    input  wire logic [15:0]         change_mask,
    input  wire logic [15:0]         device_id,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_data,
    output logic                     ok,
    output logic [2:0]               port_found,
    output logic [3:0]               port_state,
    output logic [31:0]              status_word,
    output logic [7:0]               change_bitmap
);

    // Captured command fields.
    logic [2:0]  cmd_reg;
    logic [2:0]  port_reg;
    logic [2:0]  nst_reg;
    logic [15:0] mask_reg;
    logic [15:0] dev_reg;

    // Configuration register.
    logic [15:0] delay_reg;

    // Per-port storage.
    logic [2:0]  st_reg  [PORTS];
    logic [15:0] ch_reg  [PORTS];
    logic        av_reg  [PORTS];
    logic [15:0] id_reg  [PORTS];
    logic [15:0] cd_reg  [PORTS];
    logic [2:0]  pd_reg  [PORTS];

    logic [2:0]  st_next [PORTS];
    logic [15:0] ch_next [PORTS];
    logic        av_next [PORTS];
    logic [15:0] id_next [PORTS];
    logic [15:0] cd_next [PORTS];
    logic [2:0]  pd_next [PORTS];

    // Connect and find outcome.
    logic [2:0] found_reg, found_next;
    logic       hit_reg, hit_next;

    // Result register.
    logic        ok_reg;
    logic [2:0]  pf_reg;
    logic [3:0]  ps_reg;
    logic [31:0] sw_reg;
    logic [7:0]  bm_reg;

    logic [15:0] start_val;
    logic        port_ok;

    // A zero delay behaves as a single tick.
    assign start_val = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    assign port_ok   = 32'(port_reg) < 32'(PORTS);

    // Configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= usbhpt_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            delay_reg <= cfg_data;
        end
    end

    // Capture the accepted transfer.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd;
            port_reg <= port;
            nst_reg  <= target_state;
            mask_reg <= change_mask;
            dev_reg  <= device_id;
        end
    end

    // Command execution over all ports.
    always_comb
    begin
        usbhpt_pkg::port_upd_t u;
        logic taken;
        u          = '0;
        taken      = 1'b0;
        found_next = 3'd0;
        hit_next   = 1'b0;
        for (int p = 0; p < PORTS; p++)
        begin
            st_next[p] = st_reg[p];
            ch_next[p] = ch_reg[p];
            av_next[p] = av_reg[p];
            id_next[p] = id_reg[p];
            cd_next[p] = cd_reg[p];
            pd_next[p] = pd_reg[p];
        end
        case (usbhpt_pkg::cmd_t'(cmd_reg))
            usbhpt_pkg::CMD_TICK:
            begin
                for (int p = 0; p < PORTS; p++)
                begin
                    if (cd_reg[p] != 16'd0)
                    begin
                        cd_next[p] = cd_reg[p] - 16'd1;
                        if (cd_reg[p] == 16'd1 && st_reg[p] == pd_reg[p])
                        begin
                            u = usbhpt_pkg::port_set_state(st_reg[p],
                                usbhpt_pkg::ST_ENABLED, ch_reg[p], cd_next[p],
                                pd_reg[p], start_val);
                            st_next[p] = u.state;
                            ch_next[p] = u.change;
                            cd_next[p] = u.count;
                            pd_next[p] = u.pend;
                        end
                    end
                end
            end
            usbhpt_pkg::CMD_CONNECT:
            begin
                for (int p = 0; p < PORTS; p++)
                begin
                    if (!taken && !av_reg[p])
                    begin
                        taken      = 1'b1;
                        av_next[p] = 1'b1;
                        id_next[p] = dev_reg;
                        st_next[p] = usbhpt_pkg::ST_DISABLED;
                        ch_next[p] = ch_reg[p] | usbhpt_pkg::CH_CONNECTION;
                        found_next = 3'(p);
                        hit_next   = 1'b1;
                    end
                end
            end
            usbhpt_pkg::CMD_FIND:
            begin
                for (int p = 0; p < PORTS; p++)
                begin
                    if (!taken && av_reg[p] && id_reg[p] == dev_reg)
                    begin
                        taken      = 1'b1;
                        found_next = 3'(p);
                        hit_next   = 1'b1;
                    end
                end
            end
            usbhpt_pkg::CMD_SET_STATE, usbhpt_pkg::CMD_SET_ALL:
            begin
                for (int p = 0; p < PORTS; p++)
                begin
                    if (cmd_reg == usbhpt_pkg::CMD_SET_ALL || port_reg == 3'(p))
                    begin
                        u = usbhpt_pkg::port_set_state(st_reg[p], nst_reg,
                            ch_reg[p], cd_reg[p], pd_reg[p], start_val);
                        st_next[p] = u.state;
                        ch_next[p] = u.change;
                        cd_next[p] = u.count;
                        pd_next[p] = u.pend;
                    end
                end
            end
            usbhpt_pkg::CMD_CLEAR_CHANGE:
            begin
                for (int p = 0; p < PORTS; p++)
                begin
                    if (port_reg == 3'(p))
                    begin
                        ch_next[p] = ch_reg[p] & ~mask_reg;
                    end
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase
    end

    // Per-port control state and outcome registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                st_reg[p] <= usbhpt_pkg::ST_UNCONF;
                ch_reg[p] <= 16'd0;
                av_reg[p] <= 1'b0;
                cd_reg[p] <= 16'd0;
                pd_reg[p] <= 3'd0;
            end
            found_reg <= 3'd0;
            hit_reg   <= 1'b0;
        end
        else if (dp_cmd.exec)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                st_reg[p] <= st_next[p];
                ch_reg[p] <= ch_next[p];
                av_reg[p] <= av_next[p];
                cd_reg[p] <= cd_next[p];
                pd_reg[p] <= pd_next[p];
            end
            found_reg <= found_next;
            hit_reg   <= hit_next;
        end
    end

    // Attached device ids are meaningful only while the valid bit is set.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                id_reg[p] <= id_next[p];
            end
        end
    end

    // Result formation from the updated state.
    logic        use_found;
    logic [2:0]  found_st;
    logic [2:0]  sel_st;
    logic        sel_av;
    logic [15:0] sel_ch;
    logic [7:0]  bitmap;
    logic        ok_val;
    logic [3:0]  ps_val;
    logic [31:0] sw_val;

    always_comb
    begin
        found_st = 3'd0;
        sel_st   = 3'd0;
        sel_av   = 1'b0;
        sel_ch   = 16'd0;
        bitmap   = 8'd0;
        for (int p = 0; p < PORTS; p++)
        begin
            if (found_reg == 3'(p))
            begin
                found_st = st_reg[p];
            end
            if (port_reg == 3'(p))
            begin
                sel_st = st_reg[p];
                sel_av = av_reg[p];
                sel_ch = ch_reg[p];
            end
            bitmap[p + 1] = |ch_reg[p];
        end
    end

    assign use_found = cmd_reg == usbhpt_pkg::CMD_CONNECT ||
                       cmd_reg == usbhpt_pkg::CMD_FIND;

    always_comb
    begin
        case (usbhpt_pkg::cmd_t'(cmd_reg))
            usbhpt_pkg::CMD_TICK, usbhpt_pkg::CMD_SET_ALL,
            usbhpt_pkg::CMD_READ_BITMAP:
            begin
                ok_val = 1'b1;
            end
            usbhpt_pkg::CMD_CONNECT, usbhpt_pkg::CMD_FIND:
            begin
                ok_val = hit_reg;
            end
            default:
            begin
                ok_val = port_ok;
            end
        endcase
    end

    always_comb
    begin
        if (use_found)
        begin
            ps_val = hit_reg ? {1'b0, found_st} : usbhpt_pkg::ST_UNKNOWN;
        end
        else
        begin
            ps_val = port_ok ? {1'b0, sel_st} : usbhpt_pkg::ST_UNKNOWN;
        end
    end

    // Port status word: attach, enable, suspend, reset, power and changes.
    always_comb
    begin
        sw_val = 32'd0;
        if (port_ok)
        begin
            sw_val = {sel_ch, 7'd0,
                      sel_st != usbhpt_pkg::ST_OFF, 3'd0,
                      sel_st == usbhpt_pkg::ST_RESETTING, 1'b0,
                      sel_st == usbhpt_pkg::ST_SUSPENDED ||
                          sel_st == usbhpt_pkg::ST_RESUMING,
                      sel_st == usbhpt_pkg::ST_ENABLED,
                      sel_av};
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            ok_reg <= ok_val;
            pf_reg <= found_reg;
            ps_reg <= ps_val;
            sw_reg <= sw_val;
            bm_reg <= bitmap;
        end
    end

    assign ok            = ok_reg;
    assign port_found    = pf_reg;
    assign port_state    = ps_reg;
    assign status_word   = sw_reg;
    assign change_bitmap = bm_reg;

endmodule
`default_nettype wire
